// ===== rtl/cbst_pkg.sv =====
// ---------------------------------------------------------------------------
// cbst_pkg: shared types and constants
// Field widths, command codes and the queue word used between the front end,
// the item queue and the plane test engine.
// ---------------------------------------------------------------------------
package cbst_pkg;

   // Field widths
   localparam int COORD_W    = 32;  // Q16.16 coordinate
   localparam int NORM_W     = 18;  // Q1.16 normal component
   localparam int OFF_W      = 32;  // Q16.16 plane offset
   localparam int IDX_IN_W   = 6;   // plane_index field
   localparam int CSR_W      = 7;   // plane_count register
   localparam int PROD_W     = COORD_W + NORM_W;
   localparam int ACC_W      = 52;  // three products plus shifted offset
   localparam int FRAC_SHIFT = 16;  // align Q16.16 offset with Q.32 products
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TEST = 1'b1
   } cmd_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   // One queued word: vtx[vertex][axis]
   typedef struct packed {
      cmd_type                  cmd;
      logic [IDX_IN_W-1:0]      plane_index;
      coord_type [2:0][2:0]     vtx;
      logic                     last_side;
   } item_type;

endpackage

// ===== rtl/cbst_front.sv =====
// ---------------------------------------------------------------------------
// cbst_front: request intake
// Registers one request word, drops loads aimed beyond the table and hands
// the rest to the item queue.
// ---------------------------------------------------------------------------
module cbst_front #(
   parameter int MAX_PLANES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [5:0]                req_plane_index,
   input  logic signed [31:0]        req_vertex0_x,
   input  logic signed [31:0]        req_vertex0_y,
   input  logic signed [31:0]        req_vertex0_z,
   input  logic signed [31:0]        req_vertex1_x,
   input  logic signed [31:0]        req_vertex1_y,
   input  logic signed [31:0]        req_vertex1_z,
   input  logic signed [31:0]        req_vertex2_x,
   input  logic signed [31:0]        req_vertex2_y,
   input  logic signed [31:0]        req_vertex2_z,
   input  logic                      req_last_side,
   output logic                      push_valid,
   input  logic                      push_ready,
   output cbst_pkg::item_type        push_item
);
   import cbst_pkg::*;

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_item_ff;
   item_type req_item;
   logic     req_accept;
   logic     req_keep;

   // Gather the request fields into one word
   always_comb begin
      req_item.cmd         = cmd_type'(req_cmd);
      req_item.plane_index = req_plane_index;
      req_item.vtx[0][0]   = req_vertex0_x;
      req_item.vtx[0][1]   = req_vertex0_y;
      req_item.vtx[0][2]   = req_vertex0_z;
      req_item.vtx[1][0]   = req_vertex1_x;
      req_item.vtx[1][1]   = req_vertex1_y;
      req_item.vtx[1][2]   = req_vertex1_z;
      req_item.vtx[2][0]   = req_vertex2_x;
      req_item.vtx[2][1]   = req_vertex2_y;
      req_item.vtx[2][2]   = req_vertex2_z;
      req_item.last_side   = req_last_side;
   end

   // Classify: tests always go on, loads only when the slot exists
   assign req_keep   = (cmd_type'(req_cmd) == CMD_TEST) ||
                       (32'(req_plane_index) < 32'(MAX_PLANES));
   assign req_ready  = !hold_valid_ff || push_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_accept) begin
         hold_valid_in = req_keep;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   // Hold the word until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_item_ff <= req_item;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

endmodule

// ===== rtl/cbst_queue.sv =====
// ---------------------------------------------------------------------------
// cbst_queue: short item queue
// Small first-in first-out buffer that decouples intake from the engine.
// ---------------------------------------------------------------------------
module cbst_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  cbst_pkg::item_type        push_item,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output cbst_pkg::item_type        pop_item
);
   import cbst_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/cbst_engine.sv =====
// ---------------------------------------------------------------------------
// cbst_engine: plane table and triangle test
// Writes loaded planes into the table; for a triangle, reads one plane per
// cycle, takes the three vertex distances in a four-stage pipeline and
// flags a reject when all three lie strictly in front.
// ---------------------------------------------------------------------------
module cbst_engine #(
   parameter int MAX_PLANES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  cbst_pkg::item_type          pop_item,
   input  logic [cbst_pkg::CSR_W-1:0]  plane_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_side_in_solid,
   output logic                        rsp_brush_intersects,
   output logic                        rsp_result_last
);
   import cbst_pkg::*;

   localparam int IDX_W = $clog2(MAX_PLANES);
   localparam int CNT_W = $clog2(MAX_PLANES + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
      logic signed [OFF_W-1:0]  off;
   } plane_type;

   // Plane table
   plane_type                plane_mem [MAX_PLANES];
   plane_type                rd_plane_ff;
   logic [IDX_W-1:0]         wr_addr;
   logic [IDX_W-1:0]         rd_addr;
   plane_type                wr_plane;

   // Control
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         issue_cnt_ff, issue_cnt_in;
   logic [CNT_W-1:0]         limit_ff, limit_in;
   logic [3:0]               vld_ff, vld_in;
   logic                     reject_ff, reject_in;
   logic                     hit_seen_ff, hit_seen_in;
   logic                     last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_side_ff, rsp_side_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     do_pop, pop_load, pop_test, issue, rsp_load;
   logic [CMP_W-1:0]         count_ext, count_sat;

   // Datapath
   coord_type                vtx_ff [3][3];
   logic signed [NORM_W-1:0] nrm [3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [OFF_W-1:0]  off2_ff;
   logic signed [ACC_W-1:0]  sum_a_ff [3];
   logic signed [ACC_W-1:0]  sum_b_ff [3];
   logic signed [ACC_W-1:0]  vtx_dist [3];
   logic [2:0]               front_ff;

   assign pop_ready = (state_ff == ST_IDLE);
   assign do_pop    = pop_valid && pop_ready;
   assign pop_load  = do_pop && (pop_item.cmd == CMD_LOAD);
   assign pop_test  = do_pop && (pop_item.cmd == CMD_TEST);
   assign issue     = (state_ff == ST_RUN) && (issue_cnt_ff != limit_ff);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Clamp the plane count to the table size
   assign count_ext = CMP_W'(plane_count);
   assign count_sat = (count_ext > CMP_W'(MAX_PLANES)) ? CMP_W'(MAX_PLANES) : count_ext;

   // Table write and registered read
   assign wr_addr      = IDX_W'(pop_item.plane_index);
   assign rd_addr      = issue_cnt_ff[IDX_W-1:0];
   assign wr_plane.nx  = pop_item.vtx[0][0][NORM_W-1:0];
   assign wr_plane.ny  = pop_item.vtx[0][1][NORM_W-1:0];
   assign wr_plane.nz  = pop_item.vtx[0][2][NORM_W-1:0];
   assign wr_plane.off = pop_item.vtx[1][0];

   always_ff @(posedge clock) begin
      if (pop_load) begin
         plane_mem[wr_addr] <= wr_plane;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_plane_ff <= plane_mem[rd_addr];
      end
   end

   assign nrm[0] = rd_plane_ff.nx;
   assign nrm[1] = rd_plane_ff.ny;
   assign nrm[2] = rd_plane_ff.nz;

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         vtx_dist[v] = sum_a_ff[v] + sum_b_ff[v];
      end
   end

   // Distance pipeline: products, pair sums, final sum and sign test
   always_ff @(posedge clock) begin
      if (pop_test) begin
         for (int v = 0; v < 3; v++) begin
            for (int a = 0; a < 3; a++) begin
               vtx_ff[v][a] <= pop_item.vtx[v][a];
            end
         end
      end
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 3; a++) begin
            prod_ff[v][a] <= $signed(vtx_ff[v][a]) * $signed(nrm[a]);
         end
         sum_a_ff[v] <= ACC_W'(prod_ff[v][0]) + ACC_W'(prod_ff[v][1]);
         sum_b_ff[v] <= ACC_W'(prod_ff[v][2]) + (ACC_W'(off2_ff) <<< FRAC_SHIFT);
         front_ff[v] <= !vtx_dist[v][ACC_W-1] && (vtx_dist[v] != '0);
      end
      off2_ff <= rd_plane_ff.off;
   end

   // Sequence one item at a time
   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      limit_in     = limit_ff;
      vld_in       = {vld_ff[2:0], issue};
      reject_in    = reject_ff;
      hit_seen_in  = hit_seen_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_side_in  = rsp_side_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_test) begin
               issue_cnt_in = '0;
               limit_in     = CNT_W'(count_sat);
               reject_in    = 1'b0;
               last_in      = pop_item.last_side;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (vld_ff[3] && (&front_ff)) begin
               reject_in = 1'b1;
            end
            if (!issue && (vld_ff == '0)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_side_in  = !reject_ff;
               rsp_hit_in   = hit_seen_ff || !reject_ff;
               rsp_last_in  = last_ff;
               hit_seen_in  = last_ff ? 1'b0 : (hit_seen_ff || !reject_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
         limit_ff     <= '0;
         vld_ff       <= '0;
         reject_ff    <= 1'b0;
         hit_seen_ff  <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_side_ff  <= 1'b0;
         rsp_hit_ff   <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         limit_ff     <= limit_in;
         vld_ff       <= vld_in;
         reject_ff    <= reject_in;
         hit_seen_ff  <= hit_seen_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_side_ff  <= rsp_side_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_side_in_solid    = rsp_side_ff;
   assign rsp_brush_intersects = rsp_hit_ff;
   assign rsp_result_last      = rsp_last_ff;

   // Checks
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (issue_cnt_ff <= limit_ff))
      else $error("plane read past the active count");

   a_pipe_in_run: assert property (@(posedge clock) disable iff (reset)
      (vld_ff != '0) |-> (state_ff == ST_RUN))
      else $error("distance pipeline busy outside a test");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result word raised without a finished test");

   a_hit_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_ff) |=> !hit_seen_ff)
      else $error("brush flag not cleared after the last triangle");

endmodule

// ===== rtl/convex_brush_side_in_solid_test_unit.sv =====
// ---------------------------------------------------------------------------
// convex_brush_side_in_solid_test_unit: triangle versus convex brush test
// Holds the bounding planes of one brush and tells, per triangle, whether
// it touches the solid; keeps a per-brush running flag.
// ---------------------------------------------------------------------------
// req_*: one word per item. req_cmd low loads a plane (normal in vertex0,
//   Q1.16 low 18 bits; offset in vertex1_x) at req_plane_index; req_cmd
//   high tests one triangle. rsp_*: one word per test, none per load.
// csr_*: plane_count write, taken at once (csr_ready always high); write
//   only while no word is in flight.
// Flow: a test's request word passes the intake register and the queue;
//   the engine then reads one plane per cycle, up to the plane count
//   clamped to MAX_PLANES, and a four-stage distance pipeline drains
//   before the verdict is registered on rsp_*.
// Order: the engine takes one item at a time and pops no new one until
//   a test's result word is loaded; a load only writes the table.
// Reset: the running flag clears and plane_count returns to 1; the plane
//   table holds nothing valid until loaded.
// Stall: a result held on rsp_* stalls only the engine; the queue then
//   fills and req_ready drops.
// ---------------------------------------------------------------------------
module convex_brush_side_in_solid_test_unit #(
   parameter int MAX_PLANES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [5:0]          req_plane_index,
   input  logic signed [31:0]  req_vertex0_x,
   input  logic signed [31:0]  req_vertex0_y,
   input  logic signed [31:0]  req_vertex0_z,
   input  logic signed [31:0]  req_vertex1_x,
   input  logic signed [31:0]  req_vertex1_y,
   input  logic signed [31:0]  req_vertex1_z,
   input  logic signed [31:0]  req_vertex2_x,
   input  logic signed [31:0]  req_vertex2_y,
   input  logic signed [31:0]  req_vertex2_z,
   input  logic                req_last_side,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_side_in_solid,
   output logic                rsp_brush_intersects,
   output logic                rsp_result_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [6:0]          csr_wdata
);
   import cbst_pkg::*;

   logic              push_valid, push_ready;
   item_type          push_item;
   logic              pop_valid, pop_ready;
   item_type          pop_item;
   logic [CSR_W-1:0]  plane_count_ff, plane_count_in;

   // Plane count register
   assign csr_ready      = 1'b1;
   assign plane_count_in = (csr_valid && csr_ready) ? csr_wdata : plane_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= CSR_W'(1);
      end else begin
         plane_count_ff <= plane_count_in;
      end
   end

   cbst_front #(
      .MAX_PLANES (MAX_PLANES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_plane_index (req_plane_index),
      .req_vertex0_x   (req_vertex0_x),
      .req_vertex0_y   (req_vertex0_y),
      .req_vertex0_z   (req_vertex0_z),
      .req_vertex1_x   (req_vertex1_x),
      .req_vertex1_y   (req_vertex1_y),
      .req_vertex1_z   (req_vertex1_z),
      .req_vertex2_x   (req_vertex2_x),
      .req_vertex2_y   (req_vertex2_y),
      .req_vertex2_z   (req_vertex2_z),
      .req_last_side   (req_last_side),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   cbst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   cbst_engine #(
      .MAX_PLANES (MAX_PLANES)
   ) u_engine (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_item             (pop_item),
      .plane_count          (plane_count_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_side_in_solid    (rsp_side_in_solid),
      .rsp_brush_intersects (rsp_brush_intersects),
      .rsp_result_last      (rsp_result_last)
   );

endmodule

// ===== tb/sv/tb_convex_brush_side_in_solid_test_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_convex_brush_side_in_solid_test_unit: self-checking bench
// Loads convex brushes (boxes, tangent plane sets, raw noise) into the plane
// table and streams triangle tests through the request channel. Each
// accepted word is scored at once against a local model of the plane table,
// the plane count and the per-brush hit flag. Response words are checked
// field by field, in order, while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_convex_brush_side_in_solid_test_unit;
   import cbst_pkg::*;

   localparam int MAX_PLANES   = 64;
   localparam int HALF_PERIOD  = 5;
   localparam int RANDOM_WORDS = 500;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int ONE_Q1       = 65536;
   localparam int NORM_MAX     = 131071;
   localparam int NORM_MIN     = -131072;
   localparam int COORD_MAX    = 2147483647;
   localparam int COORD_MIN    = -2147483647 - 1;

   typedef coord_type [2:0] point_type;

   typedef struct packed {
      logic side_in_solid;
      logic brush_intersects;
      logic result_last;
   } verdict_type;

   typedef enum int {
      READY_STEADY,
      READY_COIN,
      READY_LONG_STALL
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = 1'b0;
   logic [5:0]        req_plane_index = '0;
   logic signed [31:0] req_vertex0_x = '0;
   logic signed [31:0] req_vertex0_y = '0;
   logic signed [31:0] req_vertex0_z = '0;
   logic signed [31:0] req_vertex1_x = '0;
   logic signed [31:0] req_vertex1_y = '0;
   logic signed [31:0] req_vertex1_z = '0;
   logic signed [31:0] req_vertex2_x = '0;
   logic signed [31:0] req_vertex2_y = '0;
   logic signed [31:0] req_vertex2_z = '0;
   logic              req_last_side = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_side_in_solid;
   logic              rsp_brush_intersects;
   logic              rsp_result_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [6:0]        csr_wdata = '0;

   // Local copy of the plane table, plane count and hit flag
   bit signed [17:0] face_normal [MAX_PLANES][3];
   bit signed [31:0] face_offset [MAX_PLANES];
   logic [6:0]       active_faces = 7'd1;
   bit               hit_latch = 1'b0;

   item_type    word_backlog[$];
   verdict_type expected_verdicts[$];
   item_type    cur_word;
   logic        req_accepted = 1'b0;
   int          queued_words = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   ready_mode_type stall_mode = READY_STEADY;
   int          mode_left = 0;
   int          stall_left = 0;

   convex_brush_side_in_solid_test_unit #(
      .MAX_PLANES(MAX_PLANES)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_plane_index      (req_plane_index),
      .req_vertex0_x        (req_vertex0_x),
      .req_vertex0_y        (req_vertex0_y),
      .req_vertex0_z        (req_vertex0_z),
      .req_vertex1_x        (req_vertex1_x),
      .req_vertex1_y        (req_vertex1_y),
      .req_vertex1_z        (req_vertex1_z),
      .req_vertex2_x        (req_vertex2_x),
      .req_vertex2_y        (req_vertex2_y),
      .req_vertex2_z        (req_vertex2_z),
      .req_last_side        (req_last_side),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_side_in_solid    (rsp_side_in_solid),
      .rsp_brush_intersects (rsp_brush_intersects),
      .rsp_result_last      (rsp_result_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wdata            (csr_wdata)
   );

   // Clock
   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Signed distance of one vertex from one plane, exact in 64 bits
   function automatic longint face_distance(int p, point_type v);
      longint acc;
      acc = longint'(face_offset[p]) * 65536;
      for (int k = 0; k < 3; k++)
         acc += longint'(v[k]) * longint'(face_normal[p][k]);
      return acc;
   endfunction

   // Apply one accepted word to the model; queue the verdict of a test
   task automatic judge_word(input item_type w);
      int          limit;
      bit          in_solid;
      bit          ahead;
      verdict_type v;
      if (w.cmd == CMD_LOAD) begin
         for (int k = 0; k < 3; k++)
            face_normal[w.plane_index][k] = w.vtx[0][k][17:0];
         face_offset[w.plane_index] = w.vtx[1][0];
      end else begin
         limit = (active_faces > MAX_PLANES) ? MAX_PLANES : int'(active_faces);
         in_solid = 1'b1;
         for (int p = 0; p < limit && in_solid; p++) begin
            ahead = 1'b1;
            for (int k = 0; k < 3; k++)
               if (face_distance(p, w.vtx[k]) <= 0) ahead = 1'b0;
            if (ahead) in_solid = 1'b0;
         end
         v.side_in_solid    = in_solid;
         v.brush_intersects = hit_latch | in_solid;
         v.result_last      = w.last_side;
         expected_verdicts.push_back(v);
         hit_latch = w.last_side ? 1'b0 : (hit_latch | in_solid);
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (error_count < 50)
         $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic int rand_span(int unsigned half);
      return int'(longint'($urandom_range(2 * half)) - longint'(half));
   endfunction

   function automatic point_type point_of(int x, int y, int z);
      point_type p;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      return p;
   endfunction

   // Queue a plane load; the normal rides in the low 18 bits, upper bits junk at random
   task automatic push_plane(int unsigned slot, int nx, int ny, int nz, int off);
      item_type    w;
      logic [31:0] junk;
      int          raw [3];
      raw = '{nx, ny, nz};
      w.cmd = CMD_LOAD;
      w.plane_index = slot[5:0];
      for (int k = 0; k < 3; k++) begin
         junk = $urandom;
         w.vtx[0][k] = raw[k];
         if (junk[0]) w.vtx[0][k][31:18] = junk[31:18];
         w.vtx[2][k] = $urandom;
      end
      w.vtx[1][0] = off;
      w.vtx[1][1] = $urandom;
      w.vtx[1][2] = $urandom;
      w.last_side = 1'($urandom_range(1));
      word_backlog.push_back(w);
      queued_words++;
   endtask

   task automatic push_triangle(point_type a, point_type b, point_type c, bit last);
      item_type w;
      w.cmd = CMD_TEST;
      w.plane_index = 6'($urandom);
      w.vtx[0] = a;
      w.vtx[1] = b;
      w.vtx[2] = c;
      w.last_side = last;
      word_backlog.push_back(w);
      queued_words++;
   endtask

   // Small triangle around a random spot within twice the brush size
   task automatic push_cluster(int unsigned reach, bit last);
      point_type hub;
      point_type corner [3];
      hub = point_of(rand_span(2 * reach), rand_span(2 * reach), rand_span(2 * reach));
      for (int k = 0; k < 3; k++)
         for (int a = 0; a < 3; a++)
            corner[k][a] = hub[a] + rand_span(reach / 2 + 1);
      push_triangle(corner[0], corner[1], corner[2], last);
   endtask

   // Fill the first slots with a box (faces repeated) or tangent planes
   task automatic load_brush(bit boxy, int unsigned reach, int slots);
      int nrm [3];
      for (int s = 0; s < slots; s++) begin
         if (boxy) begin
            nrm = '{0, 0, 0};
            nrm[(s % 6) / 2] = (s % 2) ? -ONE_Q1 : ONE_Q1;
            push_plane(s, nrm[0], nrm[1], nrm[2], -int'(reach));
         end else begin
            push_plane(s, rand_span(ONE_Q1), rand_span(ONE_Q1), rand_span(ONE_Q1),
                       -int'($urandom_range(reach, reach / 2)));
         end
      end
   endtask

   // Wait until every word is taken and every verdict has come back
   task automatic settle();
      while (word_backlog.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_plane_count(input logic [6:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      active_faces = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Request driver: bursts with random gaps, hold each word until taken
   always @(negedge clock) begin : word_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // hold the current word
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (word_backlog.size() > 0) begin
         cur_word = word_backlog.pop_front();
         req_cmd         <= cur_word.cmd;
         req_plane_index <= cur_word.plane_index;
         req_vertex0_x   <= cur_word.vtx[0][0];
         req_vertex0_y   <= cur_word.vtx[0][1];
         req_vertex0_z   <= cur_word.vtx[0][2];
         req_vertex1_x   <= cur_word.vtx[1][0];
         req_vertex1_y   <= cur_word.vtx[1][1];
         req_vertex1_z   <= cur_word.vtx[1][2];
         req_vertex2_x   <= cur_word.vtx[2][0];
         req_vertex2_y   <= cur_word.vtx[2][1];
         req_vertex2_z   <= cur_word.vtx[2][2];
         req_last_side   <= cur_word.last_side;
         req_valid       <= 1'b1;
         if (burst_left == 0)
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(6, 1);
         burst_left--;
         if (burst_left == 0)
            gap_left = ($urandom_range(3) == 0) ? $urandom_range(80) : $urandom_range(4);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response ready: steady, coin flip, or long stalls, switching now and then
   always @(negedge clock) begin : ready_pattern
      if (mode_left == 0) begin
         stall_mode = ready_mode_type'($urandom_range(2));
         mode_left = $urandom_range(256, 64);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         READY_STEADY: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(1));
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(7) == 0) stall_left = $urandom_range(30, 1);
            end
         end
      endcase
   end

   // Score accepted request words, check response words in order
   always @(posedge clock) begin : word_monitor
      verdict_type want;
      cycle_count++;
      req_accepted <= req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         judge_word(cur_word);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("response word with no verdict pending");
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_side_in_solid !== want.side_in_solid)
               report_mismatch($sformatf("side_in_solid got %b want %b",
                                         rsp_side_in_solid, want.side_in_solid));
            if (rsp_brush_intersects !== want.brush_intersects)
               report_mismatch($sformatf("brush_intersects got %b want %b",
                                         rsp_brush_intersects, want.brush_intersects));
            if (rsp_result_last !== want.result_last)
               report_mismatch($sformatf("result_last got %b want %b",
                                         rsp_result_last, want.result_last));
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_convex_brush_side_in_solid_test_unit: errors");
      $finish;
   end

   initial begin : stimulus
      int          random_start;
      int          phase_end;
      int          run_len;
      int          in_use;
      bit          broken;
      logic [6:0]  count_value;
      int unsigned reach;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole table so no test ever reads an empty slot
      reach = 8 << 16;
      load_brush(1'b0, reach, MAX_PLANES);

      // Single plane x > 0: strictly in front vs. touching
      push_plane(0, ONE_Q1, 0, 0, 0);
      push_triangle(point_of(1, 5, -5), point_of(1, COORD_MIN, 0),
                    point_of(1, COORD_MAX, 7), 1'b0);
      push_triangle(point_of(1, 2, 3), point_of(1, -2, -3), point_of(0, 9, 9), 1'b0);
      push_triangle(point_of(COORD_MAX, COORD_MAX, COORD_MIN),
                    point_of(COORD_MAX, COORD_MIN, COORD_MAX),
                    point_of(COORD_MAX, 0, 0), 1'b1);
      push_triangle(point_of(COORD_MIN, 0, 0), point_of(COORD_MIN, 1, 1),
                    point_of(COORD_MIN, -1, -1), 1'b1);

      // Extreme normals and offsets against extreme vertices
      push_plane(0, NORM_MAX, NORM_MAX, NORM_MAX, COORD_MIN);
      push_triangle(point_of(COORD_MAX, COORD_MAX, COORD_MAX),
                    point_of(COORD_MAX, COORD_MAX, COORD_MAX),
                    point_of(COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
      push_triangle(point_of(1, 0, 0), point_of(1, 0, 0), point_of(1, 0, 0), 1'b0);
      push_plane(0, NORM_MIN, NORM_MIN, NORM_MIN, COORD_MAX);
      push_triangle(point_of(COORD_MIN, COORD_MIN, COORD_MIN),
                    point_of(COORD_MIN, COORD_MIN, COORD_MIN),
                    point_of(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1);
      push_triangle(point_of(COORD_MAX, COORD_MAX, COORD_MAX),
                    point_of(COORD_MAX, COORD_MAX, COORD_MAX),
                    point_of(COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);

      // Zero normal: positive offset rejects all, zero offset rejects none;
      // loads in between leave the hit flag alone
      push_plane(0, 0, 0, 0, 1);
      push_cluster(reach, 1'b1);
      push_plane(0, 0, 0, 0, 0);
      push_cluster(reach, 1'b0);

      // No planes active: always in solid
      push_plane(0, 0, 0, 0, 1);
      settle();
      write_plane_count(7'd0);
      push_cluster(reach, 1'b1);

      // Count above the table size clamps; only the top slot rejects here
      push_plane(0, 0, 0, 0, 0);
      push_plane(MAX_PLANES - 1, 0, 0, 0, 1);
      settle();
      write_plane_count(7'd127);
      push_triangle(point_of(0, 0, 0), point_of(0, 0, 0), point_of(0, 0, 0), 1'b0);
      settle();
      write_plane_count(7'd63);
      push_triangle(point_of(0, 0, 0), point_of(0, 0, 0), point_of(0, 0, 0), 1'b0);
      settle();
      write_plane_count(7'd64);
      push_triangle(point_of(0, 0, 0), point_of(0, 0, 0), point_of(0, 0, 0), 1'b1);

      // Random phases: new count, maybe a new brush, then brush runs and noise
      random_start = queued_words;
      while (queued_words < random_start + RANDOM_WORDS) begin
         settle();
         case ($urandom_range(9))
            0:       count_value = 7'd0;
            1:       count_value = 7'd127;
            2:       count_value = 7'd64;
            3:       count_value = 7'($urandom_range(126, 65));
            default: count_value = 7'($urandom_range(8, 1));
         endcase
         write_plane_count(count_value);
         in_use = (count_value > MAX_PLANES) ? MAX_PLANES : int'(count_value);
         if ($urandom_range(1) == 1) begin
            reach = ($urandom_range(7) == 0) ? $urandom_range(1 << 28, 1 << 24)
                                            : $urandom_range(64 << 16, 1 << 16);
            load_brush(1'($urandom_range(1)), reach, (in_use > 12) ? 12 : in_use);
         end
         phase_end = queued_words + $urandom_range(80, 30);
         while (queued_words < phase_end) begin
            case ($urandom_range(9))
               0: push_plane($urandom_range(MAX_PLANES - 1), $urandom, $urandom,
                             $urandom, $urandom);
               1: push_triangle(point_of($urandom, $urandom, $urandom),
                                point_of($urandom, $urandom, $urandom),
                                point_of($urandom, $urandom, $urandom),
                                1'($urandom_range(1)));
               default: begin
                  run_len = $urandom_range(6, 1);
                  broken = ($urandom_range(9) == 0);
                  for (int t = 1; t <= run_len; t++)
                     push_cluster(reach, t == run_len && !broken);
               end
            endcase
         end
      end

      settle();
      if (error_count == 0) begin
         $display("tb_convex_brush_side_in_solid_test_unit: clean");
      end else begin
         $display("tb_convex_brush_side_in_solid_test_unit: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cbst_pkg.sv
rtl/cbst_front.sv
rtl/cbst_queue.sv
rtl/cbst_engine.sv
rtl/convex_brush_side_in_solid_test_unit.sv
tb/sv/tb_convex_brush_side_in_solid_test_unit.sv
